>>> src/csl_pkg.sv
// Shared types, constants and keyword helpers for the C subset lexer.
package csl_pkg;

    localparam int ID_LEN_DEF = 8;
    localparam int STR_TABLE_DEF = 1024;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUM, M_BANG, M_EQ, M_LT, M_GT, M_STR, M_CH1, M_CH2
    } mode_t;

    localparam logic [5:0] K_NONE = 6'd0;
    localparam logic [5:0] K_IDENT = 6'd1;
    localparam logic [5:0] K_INTCON = 6'd2;
    localparam logic [5:0] K_CHARCON = 6'd3;
    localparam logic [5:0] K_STRINGCON = 6'd4;
    localparam logic [5:0] K_KEY0 = 6'd5;
    localparam logic [5:0] K_PLUS = 6'd18;
    localparam logic [5:0] K_MINUS = 6'd19;
    localparam logic [5:0] K_TIMES = 6'd20;
    localparam logic [5:0] K_IDIV = 6'd21;
    localparam logic [5:0] K_EQL = 6'd22;
    localparam logic [5:0] K_NEQ = 6'd23;
    localparam logic [5:0] K_GTR = 6'd24;
    localparam logic [5:0] K_GEQ = 6'd25;
    localparam logic [5:0] K_LSS = 6'd26;
    localparam logic [5:0] K_LEQ = 6'd27;
    localparam logic [5:0] K_LPARENT = 6'd28;
    localparam logic [5:0] K_RPARENT = 6'd29;
    localparam logic [5:0] K_LBRACK = 6'd30;
    localparam logic [5:0] K_RBRACK = 6'd31;
    localparam logic [5:0] K_LBRACE = 6'd32;
    localparam logic [5:0] K_RBRACE = 6'd33;
    localparam logic [5:0] K_COMMA = 6'd34;
    localparam logic [5:0] K_SEMICOLON = 6'd35;
    localparam logic [5:0] K_COLON = 6'd36;
    localparam logic [5:0] K_BECOMES = 6'd37;

    localparam logic [3:0] E_NONE = 4'd0;
    localparam logic [3:0] E_LEADZERO = 4'd1;
    localparam logic [3:0] E_TOOLARGE = 4'd2;
    localparam logic [3:0] E_BADSTR = 4'd3;
    localparam logic [3:0] E_UNTERM = 4'd4;
    localparam logic [3:0] E_ILLEGAL = 4'd5;
    localparam logic [3:0] E_BADCHAR = 4'd6;
    localparam logic [3:0] E_FULL = 4'd7;

    localparam logic [1:0] OP_CHAR = 2'd0;

    localparam logic CFG_MAX_DIGITS = 1'b0;
    localparam logic CFG_MAX_VALUE = 1'b1;

    localparam int NUM_KW = 13;
    typedef logic [55:0] kw_word_t;

    // Keywords zero-padded to seven bytes, first character in the low byte.
    function automatic kw_word_t kw_word(input int k);
        kw_word_t w;
        w = '0;
        case (k)
            0: w = 56'h65736163;
            1: w = 56'h72616863;
            2: w = 56'h74736e6f63;
            3: w = 56'h6f64;
            4: w = 56'h6669;
            5: w = 56'h746e69;
            6: w = 56'h6e69616d;
            7: w = 56'h66746e697270;
            8: w = 56'h6e7275746572;
            9: w = 56'h666e616373;
            10: w = 56'h686374697773;
            11: w = 56'h64696f76;
            12: w = 56'h656c696877;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    typedef struct packed {
        logic [5:0]  kind;
        logic [30:0] num;
        logic [63:0] text;
        logic [9:0]  start;
        logic [10:0] len;
        logic [3:0]  err;
    } token_t;

    typedef struct packed {
        logic   valid;
        logic   two;
        token_t first;
        token_t second;
    } result_t;

endpackage

>>> src/csl_string_mem.sv
// String table memory: one write port, registered read of the last written byte.
module csl_string_mem #(
    parameter int DEPTH = csl_pkg::STR_TABLE_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];
    logic [AW-1:0] last_addr_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
            last_addr_reg <= addr;
        end
        rdata <= mem[last_addr_reg];
    end
endmodule

>>> src/csl_out_queue.sv
// Result queue: holds up to two tokens per word and serves them one at a time.
module csl_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  csl_pkg::result_t  res,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_ready,
    output csl_pkg::token_t   out_tok,
    output logic              out_last
);
    logic            full_reg, full_next;
    logic            two_reg, two_next;
    logic            idx_reg, idx_next;
    csl_pkg::token_t t0_reg, t1_reg;

    logic done;
    assign out_valid = full_reg;
    assign out_tok = idx_reg ? t1_reg : t0_reg;
    assign out_last = !two_reg || idx_reg;
    assign done = full_reg && out_ready && out_last;
    // A new word may load in the same cycle the last token leaves.
    assign busy = full_reg && !done;

    always_comb
    begin
        full_next = full_reg;
        two_next = two_reg;
        idx_next = idx_reg;
        if (full_reg && out_ready)
        begin
            if (out_last)
            begin
                full_next = 1'b0;
            end
            else
            begin
                idx_next = 1'b1;
            end
        end
        if (res.valid)
        begin
            full_next = 1'b1;
            two_next = res.two;
            idx_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            two_reg <= 1'b0;
            idx_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
            two_reg <= two_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            t0_reg <= res.first;
            t1_reg <= res.second;
        end
    end
endmodule

>>> src/c_subset_lexer_core.sv
// Top level of the C subset lexer.
// The lexer takes one word per cycle and gives zero, one or two token words for
// it; a word that produces two tokens hands them out one at a time, and
// the input stalls only while earlier tokens are still waiting. Literal text is
// written into an internal string table (one byte per cycle, one write port);
// the table needs no clearing after reset. tdata in: op[1:0], char_code[9:2].
module c_subset_lexer_core #(
    parameter int ID_LEN = csl_pkg::ID_LEN_DEF,
    parameter int STR_TABLE = csl_pkg::STR_TABLE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [30:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // op, char_code
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // token_kind, number_value, ident_text, string_start, string_length, error_code
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    localparam int AW = $clog2(STR_TABLE);
    localparam int LW = AW + 1;

    logic [3:0]  max_digits_reg;
    logic [30:0] max_value_reg;
    csl_pkg::mode_t mode_reg, mode_next;
    logic [63:0] text_reg, text_next;
    logic [3:0]  tcnt_reg, tcnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [3:0]  dcnt_reg, dcnt_next;
    logic        lz_reg, lz_next;
    logic [LW-1:0] snext_reg, snext_next;
    logic [LW-1:0] lstart_reg, lstart_next;
    logic [LW-1:0] llen_reg, llen_next;
    logic [3:0]  perr_reg, perr_next;

    logic busy, acc_in, eol, we;
    logic [7:0] c, wchar, rdata;
    logic [1:0] op;
    csl_pkg::result_t res;
    csl_pkg::token_t otok;

    assign op = s_axis_tdata[1:0];
    assign eol = op != csl_pkg::OP_CHAR;
    assign c = eol ? 8'h20 : s_axis_tdata[9:2];
    assign s_axis_tready = !busy;
    assign acc_in = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_digits_reg <= 4'd10;
            max_value_reg <= 31'h7fffffff;
        end
        else if (cfg_we)
        begin
            if (cfg_index == csl_pkg::CFG_MAX_DIGITS)
            begin
                max_digits_reg <= cfg_data[3:0];
            end
            else
            begin
                max_value_reg <= cfg_data;
            end
        end
    end

    function automatic csl_pkg::token_t tk(input logic [5:0] k, input logic [3:0] e);
        csl_pkg::token_t t;
        t = '0;
        t.kind = k;
        t.err = e;
        return t;
    endfunction

    // Keyword match on the case-folded buffer.
    logic [5:0] id_kind;
    always_comb
    begin
        logic [63:0] f;
        logic [7:0] b;
        f = '0;
        for (int i = 0; i < 8; i++)
        begin
            b = text_reg[8*i +: 8];
            if (b >= 8'h41 && b <= 8'h5a)
            begin
                b = b + 8'd32;
            end
            if (4'(i) < tcnt_reg)
            begin
                f[8*i +: 8] = b;
            end
        end
        id_kind = csl_pkg::K_IDENT;
        for (int k = csl_pkg::NUM_KW - 1; k >= 0; k--)
        begin
            if (f == {8'h00, csl_pkg::kw_word(k)})
            begin
                id_kind = csl_pkg::K_KEY0 + 6'(k);
            end
        end
    end

    // Number finishing.
    csl_pkg::token_t num_tok;
    always_comb
    begin
        logic [31:0] v;
        logic [3:0] n;
        logic [3:0] e;
        v = acc_reg;
        n = dcnt_reg;
        e = csl_pkg::E_NONE;
        if (n > 4'd1 && lz_reg)
        begin
            e = csl_pkg::E_LEADZERO;
            v = '0;
            n = 4'd1;
        end
        if (n > max_digits_reg || v > {1'b0, max_value_reg})
        begin
            e = csl_pkg::E_TOOLARGE;
            v = '0;
        end
        num_tok = tk(csl_pkg::K_INTCON, e);
        num_tok.num = v[30:0];
    end

    logic [35:0] acc_x10;
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 36'(c - 8'h30);

    always_comb
    begin
        csl_pkg::token_t t1, t2;
        logic start, n_emit, full, stored;
        logic [3:0] pe;
        mode_next = mode_reg;
        text_next = text_reg;
        tcnt_next = tcnt_reg;
        acc_next = acc_reg;
        dcnt_next = dcnt_reg;
        lz_next = lz_reg;
        snext_next = snext_reg;
        lstart_next = lstart_reg;
        llen_next = llen_reg;
        perr_next = perr_reg;
        we = 1'b0;
        wchar = c;
        t1 = '0;
        t2 = '0;
        n_emit = 1'b0;
        start = 1'b0;
        res = '0;
        full = snext_reg >= LW'(STR_TABLE);
        stored = 1'b0;
        pe = perr_reg;
        case (mode_reg)
            csl_pkg::M_IDENT:
            begin
                if (csl_pkg::is_letter(c) || csl_pkg::is_digit(c) || c == 8'h5f)
                begin
                    if (tcnt_reg < 4'(ID_LEN))
                    begin
                        text_next[8*tcnt_reg[2:0] +: 8] = c;
                        tcnt_next = tcnt_reg + 4'd1;
                    end
                end
                else
                begin
                    t1 = tk(id_kind, csl_pkg::E_NONE);
                    t1.text = text_reg;
                    n_emit = 1'b1;
                    start = 1'b1;
                end
            end
            csl_pkg::M_NUM:
            begin
                if (csl_pkg::is_digit(c))
                begin
                    acc_next = (acc_x10 > 36'hffffffff) ? 32'hffffffff : acc_x10[31:0];
                    if (dcnt_reg < 4'd15)
                    begin
                        dcnt_next = dcnt_reg + 4'd1;
                    end
                end
                else
                begin
                    t1 = num_tok;
                    n_emit = 1'b1;
                    start = 1'b1;
                end
            end
            csl_pkg::M_BANG:
            begin
                if (c == 8'h3d && !eol)
                begin
                    t1 = tk(csl_pkg::K_NEQ, csl_pkg::E_NONE);
                    n_emit = 1'b1;
                    mode_next = csl_pkg::M_IDLE;
                end
                else
                begin
                    start = 1'b1;
                end
            end
            csl_pkg::M_EQ, csl_pkg::M_LT, csl_pkg::M_GT:
            begin
                n_emit = 1'b1;
                if (c == 8'h3d && !eol)
                begin
                    mode_next = csl_pkg::M_IDLE;
                    t1 = tk(mode_reg == csl_pkg::M_EQ ? csl_pkg::K_EQL :
                            mode_reg == csl_pkg::M_LT ? csl_pkg::K_LEQ : csl_pkg::K_GEQ,
                            csl_pkg::E_NONE);
                end
                else
                begin
                    start = 1'b1;
                    t1 = tk(mode_reg == csl_pkg::M_EQ ? csl_pkg::K_BECOMES :
                            mode_reg == csl_pkg::M_LT ? csl_pkg::K_LSS : csl_pkg::K_GTR,
                            csl_pkg::E_NONE);
                end
            end
            csl_pkg::M_STR:
            begin
                t1 = tk(csl_pkg::K_STRINGCON, csl_pkg::E_NONE);
                t1.start = lstart_reg[9:0];
                if (!eol && c == 8'h22)
                begin
                    t1.len = 11'(llen_reg);
                    t1.err = perr_reg;
                    n_emit = 1'b1;
                    mode_next = csl_pkg::M_IDLE;
                end
                else
                begin
                    if ((c < 8'd32 || c > 8'd126) && pe < csl_pkg::E_BADSTR)
                    begin
                        pe = csl_pkg::E_BADSTR;
                    end
                    stored = !full;
                    if (full)
                    begin
                        pe = csl_pkg::E_FULL;
                    end
                    if (eol && pe < csl_pkg::E_UNTERM)
                    begin
                        pe = csl_pkg::E_UNTERM;
                    end
                    perr_next = pe;
                    if (eol)
                    begin
                        t1.len = 11'(llen_reg + LW'(stored));
                        t1.err = pe;
                        n_emit = 1'b1;
                        mode_next = csl_pkg::M_IDLE;
                    end
                end
            end
            csl_pkg::M_CH1:
            begin
                mode_next = csl_pkg::M_IDLE;
                if (eol)
                begin
                    t1 = tk(csl_pkg::K_NONE, csl_pkg::E_UNTERM);
                    n_emit = 1'b1;
                end
                else if (c == 8'h27)
                begin
                    t1 = tk(csl_pkg::K_NONE, csl_pkg::E_BADCHAR);
                    n_emit = 1'b1;
                end
                else
                begin
                    if (!(csl_pkg::is_letter(c) || csl_pkg::is_digit(c) || c == 8'h2b ||
                          c == 8'h2d || c == 8'h2a || c == 8'h2f || c == 8'h5f))
                    begin
                        pe = csl_pkg::E_BADCHAR;
                    end
                    stored = !full;
                    if (full)
                    begin
                        pe = csl_pkg::E_FULL;
                    end
                    perr_next = pe;
                    acc_next = {24'b0, c};
                    mode_next = csl_pkg::M_CH2;
                end
            end
            csl_pkg::M_CH2:
            begin
                mode_next = csl_pkg::M_IDLE;
                if ((eol || c != 8'h27) && pe < csl_pkg::E_UNTERM)
                begin
                    pe = csl_pkg::E_UNTERM;
                end
                t1 = tk(csl_pkg::K_CHARCON, pe);
                t1.num = acc_reg[30:0];
                n_emit = 1'b1;
            end
            default:
            begin
                start = 1'b1;
            end
        endcase
        if (stored)
        begin
            we = 1'b1;
            snext_next = snext_reg + LW'(1);
            llen_next = llen_reg + LW'(1);
        end
        if (start)
        begin
            mode_next = csl_pkg::M_IDLE;
            if (!eol && c != 8'h20 && c != 8'h09)
            begin
                if (csl_pkg::is_letter(c) || c == 8'h5f)
                begin
                    mode_next = csl_pkg::M_IDENT;
                    text_next = {56'b0, c};
                    tcnt_next = 4'd1;
                end
                else if (csl_pkg::is_digit(c))
                begin
                    mode_next = csl_pkg::M_NUM;
                    acc_next = 32'(c - 8'h30);
                    dcnt_next = 4'd1;
                    lz_next = c == 8'h30;
                end
                else
                begin
                    case (c)
                        8'h21: mode_next = csl_pkg::M_BANG;
                        8'h3d: mode_next = csl_pkg::M_EQ;
                        8'h3c: mode_next = csl_pkg::M_LT;
                        8'h3e: mode_next = csl_pkg::M_GT;
                        8'h22:
                        begin
                            mode_next = csl_pkg::M_STR;
                            lstart_next = snext_reg;
                            llen_next = '0;
                            perr_next = csl_pkg::E_NONE;
                        end
                        8'h27:
                        begin
                            mode_next = csl_pkg::M_CH1;
                            perr_next = csl_pkg::E_NONE;
                        end
                        8'h3a: t2 = tk(csl_pkg::K_COLON, csl_pkg::E_NONE);
                        8'h28: t2 = tk(csl_pkg::K_LPARENT, csl_pkg::E_NONE);
                        8'h7b: t2 = tk(csl_pkg::K_LBRACE, csl_pkg::E_NONE);
                        8'h2b: t2 = tk(csl_pkg::K_PLUS, csl_pkg::E_NONE);
                        8'h2d: t2 = tk(csl_pkg::K_MINUS, csl_pkg::E_NONE);
                        8'h2a: t2 = tk(csl_pkg::K_TIMES, csl_pkg::E_NONE);
                        8'h2f: t2 = tk(csl_pkg::K_IDIV, csl_pkg::E_NONE);
                        8'h29: t2 = tk(csl_pkg::K_RPARENT, csl_pkg::E_NONE);
                        8'h7d: t2 = tk(csl_pkg::K_RBRACE, csl_pkg::E_NONE);
                        8'h2c: t2 = tk(csl_pkg::K_COMMA, csl_pkg::E_NONE);
                        8'h5b: t2 = tk(csl_pkg::K_LBRACK, csl_pkg::E_NONE);
                        8'h5d: t2 = tk(csl_pkg::K_RBRACK, csl_pkg::E_NONE);
                        8'h3b: t2 = tk(csl_pkg::K_SEMICOLON, csl_pkg::E_NONE);
                        default: t2 = tk(csl_pkg::K_NONE, csl_pkg::E_ILLEGAL);
                    endcase
                end
            end
        end
        // A second token exists when the restarting byte is a one-character token or an illegal byte.
        if (t2.kind != csl_pkg::K_NONE || t2.err != csl_pkg::E_NONE)
        begin
            if (n_emit)
            begin
                res.first = t1;
                res.second = t2;
                res.two = 1'b1;
            end
            else
            begin
                res.first = t2;
            end
            res.valid = acc_in;
        end
        else if (n_emit)
        begin
            res.first = t1;
            res.valid = acc_in;
        end
        if (!acc_in)
        begin
            we = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= csl_pkg::M_IDLE;
            text_reg <= '0;
            tcnt_reg <= '0;
            acc_reg <= '0;
            dcnt_reg <= '0;
            lz_reg <= 1'b0;
            snext_reg <= '0;
            lstart_reg <= '0;
            llen_reg <= '0;
            perr_reg <= '0;
        end
        else if (acc_in)
        begin
            mode_reg <= mode_next;
            text_reg <= text_next;
            tcnt_reg <= tcnt_next;
            acc_reg <= acc_next;
            dcnt_reg <= dcnt_next;
            lz_reg <= lz_next;
            snext_reg <= snext_next;
            lstart_reg <= lstart_next;
            llen_reg <= llen_next;
            perr_reg <= perr_next;
        end
    end

    csl_string_mem #(.DEPTH(STR_TABLE)) u_mem (
        .clk   (clk),
        .we    (we),
        .addr  (snext_reg[AW-1:0]),
        .wdata (wchar),
        .rdata (rdata)
    );

    csl_out_queue u_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .busy      (busy),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tok   (otok),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b0, otok.err, otok.len, otok.start, otok.text,
                           otok.num, otok.kind};

    // A stored byte reads back from the table once its address and the read data are registered.
    logic we_d;
    logic [7:0] wchar_d;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            we_d <= 1'b0;
            wchar_d <= '0;
        end
        else
        begin
            we_d <= we;
            wchar_d <= wchar;
        end
    end

    a_mem: assert property (@(posedge clk) disable iff (!rst_n)
        we_d |=> rdata == $past(wchar_d))
        else $error("string table write lost");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        snext_reg <= LW'(STR_TABLE))
        else $error("string pointer past table");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("pending token dropped");
endmodule

>>> bench/tb_c_subset_lexer_core.sv
// Self-checking testbench for the C subset lexer core.
`timescale 1ns / 1ps

module tb_c_subset_lexer_core;

    localparam int CYCLE_LIMIT = 600000;
    localparam logic [1:0] OP_EOL = 2'd1;
    localparam logic [1:0] OP_EOF = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [5:0]  kind;
        logic [30:0] num;
        logic [63:0] text;
        logic [9:0]  start;
        logic [10:0] len;
        logic [3:0]  err;
        logic        last;
    } lex_token_t;

    typedef struct {
        logic [1:0] op;
        logic [7:0] ch;
        bit         typed;
        logic [5:0] kind;
        logic [3:0] err;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [0:0]   cfg_index;
    logic [30:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;   // op, char_code
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // token_kind, number_value, ident_text, string_start, string_length, error_code
    logic [127:0] m_axis_tdata;
    logic         m_axis_tlast;

    c_subset_lexer_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // Lexer state mirrored in the predictor.
    logic [3:0]  lim_digits;
    logic [30:0] lim_value;
    csl_pkg::mode_t lx_mode;
    logic [63:0] lx_text;
    int          lx_text_cnt;
    logic [31:0] lx_accum;
    int          lx_digits;
    bit          lx_lead0;
    int          tbl_next;
    int          lit_start;
    int          lit_len;
    logic [3:0]  lit_err;

    lex_token_t  token_q[$];
    lex_token_t  step_out[$];
    int          errors;
    int          words_in;
    int          tokens_seen;
    int          cycles;
    int          burst_left;
    string       keywords[13] = '{"case", "char", "const", "do", "if", "int", "main",
                                  "printf", "return", "scanf", "switch", "void", "while"};

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit letter_c(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit digit_c(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void push_token(logic [5:0] k, logic [30:0] n, logic [63:0] t,
                                       int st, int ln, logic [3:0] e);
        lex_token_t tk;
        tk.kind = k;
        tk.num = n;
        tk.text = t;
        tk.start = st[9:0];
        tk.len = ln[10:0];
        tk.err = e;
        tk.last = 1'b0;
        step_out.push_back(tk);
    endfunction

    function automatic void bump_err(logic [3:0] e);
        if (e > lit_err)
            lit_err = e;
    endfunction

    function automatic void table_put();
        if (tbl_next < csl_pkg::STR_TABLE_DEF)
        begin
            tbl_next++;
            lit_len++;
        end
        else
            bump_err(csl_pkg::E_FULL);
    endfunction

    function automatic void close_ident();
        string      low;
        logic [7:0] b;
        logic [5:0] k;
        low = "";
        k = csl_pkg::K_IDENT;
        for (int i = 0; i < lx_text_cnt; i++)
        begin
            b = lx_text[8*i +: 8];
            if (b >= "A" && b <= "Z")
                b = b + 8'd32;
            low = {low, string'(b)};
        end
        for (int i = 0; i < 13; i++)
            if (k == csl_pkg::K_IDENT && low == keywords[i])
                k = csl_pkg::K_KEY0 + 6'(i);
        push_token(k, '0, lx_text, 0, 0, csl_pkg::E_NONE);
    endfunction

    function automatic void close_number();
        logic [3:0]  e;
        logic [31:0] v;
        int          n;
        e = csl_pkg::E_NONE;
        v = lx_accum;
        n = lx_digits;
        if (n > 1 && lx_lead0)
        begin
            e = csl_pkg::E_LEADZERO;
            v = '0;
            n = 1;
        end
        if (n > lim_digits || v > {1'b0, lim_value})
        begin
            e = csl_pkg::E_TOOLARGE;
            v = '0;
        end
        push_token(csl_pkg::K_INTCON, v[30:0], '0, 0, 0, e);
    endfunction

    function automatic void open_token(logic [7:0] c);
        logic [5:0] k;
        k = csl_pkg::K_NONE;
        if (c == " " || c == 8'h09)
            return;
        if (letter_c(c) || c == "_")
        begin
            lx_mode = csl_pkg::M_IDENT;
            lx_text = {56'd0, c};
            lx_text_cnt = 1;
            return;
        end
        if (digit_c(c))
        begin
            lx_mode = csl_pkg::M_NUM;
            lx_accum = 32'(c - "0");
            lx_digits = 1;
            lx_lead0 = (c == "0");
            return;
        end
        case (c)
            "!": lx_mode = csl_pkg::M_BANG;
            "=": lx_mode = csl_pkg::M_EQ;
            "<": lx_mode = csl_pkg::M_LT;
            ">": lx_mode = csl_pkg::M_GT;
            "\"":
            begin
                lx_mode = csl_pkg::M_STR;
                lit_start = tbl_next;
                lit_len = 0;
                lit_err = csl_pkg::E_NONE;
            end
            8'h27:
            begin
                lx_mode = csl_pkg::M_CH1;
                lit_err = csl_pkg::E_NONE;
            end
            ":": k = csl_pkg::K_COLON;
            "(": k = csl_pkg::K_LPARENT;
            "{": k = csl_pkg::K_LBRACE;
            "+": k = csl_pkg::K_PLUS;
            "-": k = csl_pkg::K_MINUS;
            "*": k = csl_pkg::K_TIMES;
            "/": k = csl_pkg::K_IDIV;
            ")": k = csl_pkg::K_RPARENT;
            "}": k = csl_pkg::K_RBRACE;
            ",": k = csl_pkg::K_COMMA;
            "[": k = csl_pkg::K_LBRACK;
            "]": k = csl_pkg::K_RBRACK;
            ";": k = csl_pkg::K_SEMICOLON;
            default: k = csl_pkg::K_NONE;
        endcase
        if (lx_mode != csl_pkg::M_IDLE)
            return;
        if (k != csl_pkg::K_NONE)
            push_token(k, '0, '0, 0, 0, csl_pkg::E_NONE);
        else
            push_token(csl_pkg::K_NONE, '0, '0, 0, 0, csl_pkg::E_ILLEGAL);
    endfunction

    // Returns the tokens one accepted word produces, in order, in step_out.
    function automatic void lex_word(logic [1:0] op, logic [7:0] ch);
        logic [7:0]  c;
        bit          eol;
        bit          fall;
        logic [63:0] v;
        step_out.delete();
        eol = (op != csl_pkg::OP_CHAR);
        c = eol ? 8'h20 : ch;
        fall = 1'b1;
        case (lx_mode)
            csl_pkg::M_IDENT:
                if (letter_c(c) || digit_c(c) || c == "_")
                begin
                    if (lx_text_cnt < csl_pkg::ID_LEN_DEF)
                    begin
                        lx_text[8*lx_text_cnt +: 8] = c;
                        lx_text_cnt++;
                    end
                    fall = 1'b0;
                end
                else
                    close_ident();
            csl_pkg::M_NUM:
                if (digit_c(c))
                begin
                    v = 64'(lx_accum) * 10 + 64'(c - "0");
                    lx_accum = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
                    if (lx_digits < 15)
                        lx_digits++;
                    fall = 1'b0;
                end
                else
                    close_number();
            csl_pkg::M_BANG:
                if (c == "=")
                begin
                    push_token(csl_pkg::K_NEQ, '0, '0, 0, 0, csl_pkg::E_NONE);
                    lx_mode = csl_pkg::M_IDLE;
                    fall = 1'b0;
                end
            csl_pkg::M_EQ, csl_pkg::M_LT, csl_pkg::M_GT:
            begin
                if (c == "=")
                begin
                    push_token(lx_mode == csl_pkg::M_EQ ? csl_pkg::K_EQL :
                               lx_mode == csl_pkg::M_LT ? csl_pkg::K_LEQ : csl_pkg::K_GEQ,
                               '0, '0, 0, 0, csl_pkg::E_NONE);
                    lx_mode = csl_pkg::M_IDLE;
                    fall = 1'b0;
                end
                else
                    push_token(lx_mode == csl_pkg::M_EQ ? csl_pkg::K_BECOMES :
                               lx_mode == csl_pkg::M_LT ? csl_pkg::K_LSS : csl_pkg::K_GTR,
                               '0, '0, 0, 0, csl_pkg::E_NONE);
            end
            csl_pkg::M_STR:
            begin
                fall = 1'b0;
                if (!eol && c == "\"")
                begin
                    push_token(csl_pkg::K_STRINGCON, '0, '0, lit_start, lit_len, lit_err);
                    lx_mode = csl_pkg::M_IDLE;
                end
                else
                begin
                    if (c < 8'd32 || c > 8'd126)
                        bump_err(csl_pkg::E_BADSTR);
                    table_put();
                    if (eol)
                    begin
                        bump_err(csl_pkg::E_UNTERM);
                        push_token(csl_pkg::K_STRINGCON, '0, '0, lit_start, lit_len,
                                   lit_err);
                        lx_mode = csl_pkg::M_IDLE;
                    end
                end
            end
            csl_pkg::M_CH1:
            begin
                fall = 1'b0;
                lx_mode = csl_pkg::M_IDLE;
                if (eol)
                    push_token(csl_pkg::K_NONE, '0, '0, 0, 0, csl_pkg::E_UNTERM);
                else if (c == 8'h27)
                    push_token(csl_pkg::K_NONE, '0, '0, 0, 0, csl_pkg::E_BADCHAR);
                else
                begin
                    if (!(letter_c(c) || digit_c(c) || c == "+" || c == "-" ||
                          c == "*" || c == "/" || c == "_"))
                        bump_err(csl_pkg::E_BADCHAR);
                    table_put();
                    lx_accum = {24'd0, c};
                    lx_mode = csl_pkg::M_CH2;
                end
            end
            csl_pkg::M_CH2:
            begin
                fall = 1'b0;
                lx_mode = csl_pkg::M_IDLE;
                if (eol || c != 8'h27)
                    bump_err(csl_pkg::E_UNTERM);
                push_token(csl_pkg::K_CHARCON, lx_accum[30:0], '0, 0, 0, lit_err);
            end
            default: ;
        endcase
        if (fall)
        begin
            lx_mode = csl_pkg::M_IDLE;
            if (!eol)
                open_token(c);
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    // Drives one word, in bursts with random gaps, and predicts it once accepted.
    task automatic send_word(logic [1:0] op, logic [7:0] ch);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, ch, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_in++;
        lex_word(op, ch);
        foreach (step_out[i])
            token_q.push_back(step_out[i]);
    endtask

    task automatic drain_tokens();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limits(logic [3:0] digits, logic [30:0] value);
        drain_tokens();
        cfg_we <= 1'b1;
        cfg_index <= csl_pkg::CFG_MAX_DIGITS;
        cfg_data <= {27'd0, digits};
        @(posedge clk);
        cfg_index <= csl_pkg::CFG_MAX_VALUE;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_digits = digits;
        lim_value = value;
        @(posedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_word(csl_pkg::OP_CHAR, s[i]);
    endtask

    function automatic logic [7:0] ident_char(bit first);
        int r;
        r = $urandom_range(0, first ? 10 : 13);
        if (r < 5)
            return 8'($urandom_range("a", "z"));
        if (r < 9)
            return 8'($urandom_range("A", "Z"));
        if (r < 11)
            return "_";
        return 8'($urandom_range("0", "9"));
    endfunction

    // One well-formed token (or a piece of noise) with random content.
    task automatic send_random_token();
        string ops[19] = '{"+", "-", "*", "/", "==", "!=", ">", ">=", "<", "<=", "(",
                           ")", "[", "]", "{", "}", ",", ";", ":"};
        string w;
        int    n;
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0, 1:
            begin
                n = $urandom_range(1, 11);
                for (int i = 0; i < n; i++)
                    send_word(csl_pkg::OP_CHAR, ident_char(i == 0));
            end
            2:
            begin
                w = keywords[$urandom_range(0, 12)];
                for (int i = 0; i < w.len(); i++)
                    send_word(csl_pkg::OP_CHAR,
                              ($urandom_range(0, 2) == 0) ? w[i] - 8'd32 : w[i]);
            end
            3, 4:
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 13) : $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    send_word(csl_pkg::OP_CHAR, 8'($urandom_range("0", "9")));
            end
            5:
            begin
                send_word(csl_pkg::OP_CHAR, "\"");
                n = $urandom_range(0, 24);
                for (int i = 0; i < n; i++)
                begin
                    c = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(32, 126));
                    if (c == "\"")
                        c = "a";
                    send_word(csl_pkg::OP_CHAR, c);
                end
                if ($urandom_range(0, 7) == 0)
                    send_word(OP_EOL, 8'($urandom));
                else
                    send_word(csl_pkg::OP_CHAR, "\"");
            end
            6:
            begin
                send_word(csl_pkg::OP_CHAR, 8'h27);
                c = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(32, 126)) : ident_char(0);
                send_word(csl_pkg::OP_CHAR, c);
                send_word(csl_pkg::OP_CHAR,
                          ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'h27);
            end
            7, 8, 9:
                send_text(ops[$urandom_range(0, 18)]);
            10:
                send_text($urandom_range(0, 1) ? "=" : "!");
            11:
                send_word(csl_pkg::OP_CHAR, 8'($urandom_range(0, 255)));
            12:
                send_word(2'($urandom_range(1, 3)), 8'($urandom));
            default:
                send_word(csl_pkg::OP_CHAR, $urandom_range(0, 3) == 0 ? 8'h09 : " ");
        endcase
    endtask

    // Receiver stall pattern: random stretches that are either fully open or have random stalls.
    int ready_mode;
    int ready_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_mode <= 0;
            ready_left <= 0;
        end
        else
        begin
            if (ready_left == 0)
            begin
                ready_mode <= $urandom_range(0, 2);
                ready_left <= $urandom_range(10, 80);
            end
            else
                ready_left <= ready_left - 1;
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // Token checker.
    always @(posedge clk)
    begin
        lex_token_t got;
        lex_token_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[5:0], m_axis_tdata[36:6], m_axis_tdata[100:37],
                   m_axis_tdata[110:101], m_axis_tdata[121:111], m_axis_tdata[125:122],
                   m_axis_tlast};
            tokens_seen++;
            if (token_q.size() == 0)
            begin
                $display("%0t: unexpected token word %h", $time, got);
                errors++;
            end
            else
            begin
                want = token_q.pop_front();
                if (got.kind !== want.kind)
                    $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
                if (got.num !== want.num)
                    $display("%0t: value exp %0d got %0d", $time, want.num, got.num);
                if (got.text !== want.text)
                    $display("%0t: text exp %h got %h", $time, want.text, got.text);
                if (got.start !== want.start)
                    $display("%0t: start exp %0d got %0d", $time, want.start, got.start);
                if (got.len !== want.len)
                    $display("%0t: length exp %0d got %0d", $time, want.len, got.len);
                if (got.err !== want.err)
                    $display("%0t: error exp %0d got %0d", $time, want.err, got.err);
                if (got.last !== want.last)
                    $display("%0t: last exp %0b got %0b", $time, want.last, got.last);
                if (got !== want)
                    errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        rows = '{
            '{csl_pkg::OP_CHAR, ";", 1, csl_pkg::K_SEMICOLON, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, 8'hFF, 1, csl_pkg::K_NONE, csl_pkg::E_ILLEGAL},
            '{csl_pkg::OP_CHAR, 8'h00, 1, csl_pkg::K_NONE, csl_pkg::E_ILLEGAL},
            '{csl_pkg::OP_CHAR, "!", 0, csl_pkg::K_NONE, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, "x", 0, csl_pkg::K_NONE, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, "!", 1, csl_pkg::K_IDENT, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, "=", 1, csl_pkg::K_NEQ, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, "0", 0, csl_pkg::K_NONE, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, "7", 0, csl_pkg::K_NONE, csl_pkg::E_NONE},
            '{OP_EOL, 8'h00, 1, csl_pkg::K_INTCON, csl_pkg::E_LEADZERO},
            '{csl_pkg::OP_CHAR, 8'h27, 0, csl_pkg::K_NONE, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, 8'h27, 1, csl_pkg::K_NONE, csl_pkg::E_BADCHAR},
            '{csl_pkg::OP_CHAR, 8'h27, 0, csl_pkg::K_NONE, csl_pkg::E_NONE},
            '{OP_EOF, 8'h00, 1, csl_pkg::K_NONE, csl_pkg::E_UNTERM},
            '{csl_pkg::OP_CHAR, "\"", 0, csl_pkg::K_NONE, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, 8'h01, 0, csl_pkg::K_NONE, csl_pkg::E_NONE},
            '{OP_SPARE, 8'hFF, 1, csl_pkg::K_STRINGCON, csl_pkg::E_UNTERM},
            '{csl_pkg::OP_CHAR, "I", 0, csl_pkg::K_NONE, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, "F", 0, csl_pkg::K_NONE, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, 8'h09, 1, csl_pkg::K_KEY0 + 6'd4, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, "<", 0, csl_pkg::K_NONE, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, "=", 1, csl_pkg::K_LEQ, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, ">", 0, csl_pkg::K_NONE, csl_pkg::E_NONE},
            '{csl_pkg::OP_CHAR, "a", 1, csl_pkg::K_GTR, csl_pkg::E_NONE},
            '{OP_EOF, 8'h00, 1, csl_pkg::K_IDENT, csl_pkg::E_NONE}
        };
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        errors = 0;
        words_in = 0;
        tokens_seen = 0;
        burst_left = 0;
        lim_digits = 4'd10;
        lim_value = 31'h7FFF_FFFF;
        lx_mode = csl_pkg::M_IDLE;
        lx_text = '0;
        lx_text_cnt = 0;
        lx_accum = '0;
        lx_digits = 0;
        lx_lead0 = 0;
        tbl_next = 0;
        lit_start = 0;
        lit_len = 0;
        lit_err = csl_pkg::E_NONE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words straight out of reset, typed expectations on the first token.
        foreach (rows[i])
        begin
            send_word(rows[i].op, rows[i].ch);
            if (rows[i].typed && (step_out.size() == 0 || step_out[0].kind != rows[i].kind
                                  || step_out[0].err != rows[i].err))
            begin
                $display("%0t: row %0d exp kind %0d err %0d, predictor disagrees",
                         $time, i, rows[i].kind, rows[i].err);
                errors++;
            end
        end

        // Random phases under different literal limits, tightest and loosest included.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_limits(4'd10, 31'h7FFF_FFFF);
                1: set_limits(4'd1, 31'd0);
                2: set_limits(4'd5, 31'd99999);
                3: set_limits(4'd3, 31'($urandom_range(0, 999)));
                4: set_limits(4'($urandom_range(1, 10)), 31'($urandom));
                default: set_limits(4'd10, 31'd2147483000);
            endcase
            while (words_in < 25 + (ph + 1) * 305)
                send_random_token();
            send_word(OP_EOL, 8'h00);
        end

        drain_tokens();
        repeat (20) @(posedge clk);
        $display("Lexed %0d words into %0d tokens over six limit settings.",
                 words_in, tokens_seen);
        $display("String table use reached %0d of %0d entries.", tbl_next,
                 csl_pkg::STR_TABLE_DEF);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
